### src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define EATRM_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// checked at every edge, reset included
`define EATRM_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) else $error("assertion failed");

`endif

### src/eatrm_pkg.sv
// package with constants, types and helpers of the rotation basis block
`timescale 1ns / 1ps

package eatrm_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int OUT_BITS   = FRAC_BITS + 2;
   localparam int IQ         = 30;
   localparam int ITERS      = 32;
   localparam int XY_BITS    = 34;
   localparam int Z_BITS     = 33;

   // cordic: load, iterations, quadrant fix; mixer: five stages
   localparam int CORDIC_LAT = ITERS + 2;
   localparam int MIX_LAT    = 5;
   localparam int LAT        = CORDIC_LAT + MIX_LAT;

   localparam logic signed [XY_BITS-1:0] CORDIC_K = XY_BITS'(652032874);
   localparam logic signed [XY_BITS-1:0] ONE_Q30  = XY_BITS'(64'sd1 <<< IQ);

   localparam logic [29:0] ATAN_TURNS [ITERS] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
      30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
      30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
      30'h00000001, 30'h00000000
   };

   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] c;
   } trig_type;

   typedef logic signed [OUT_BITS-1:0] entry_type;

   // q30 value scaled to q60
   function automatic logic signed [63:0] scale_q30(input logic signed [31:0] v);
      logic signed [63:0] w;
      w = {{32{v[31]}}, v};
      return w <<< IQ;
   endfunction

   // round a q60 sum to the output format and saturate
   function automatic entry_type to_out(input logic signed [63:0] q60);
      logic signed [63:0] r;
      logic signed [63:0] lim;
      r   = (q60 + (64'sd1 <<< (2*IQ - FRAC_BITS - 1))) >>> (2*IQ - FRAC_BITS);
      lim = 64'sd1 <<< FRAC_BITS;
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r[OUT_BITS-1:0];
   endfunction

endpackage

### src/eatrm_cordic.sv
// pipelined cordic giving clamped sine and cosine of one binary angle
`timescale 1ns / 1ps

module eatrm_cordic (
   input  logic                            clock,
   input  logic                            en,
   input  logic [eatrm_pkg::ANGLE_BITS-1:0] angle,
   output eatrm_pkg::trig_type             trig
);
   import eatrm_pkg::*;

   logic signed [XY_BITS-1:0] x_ff [ITERS+1];
   logic signed [XY_BITS-1:0] y_ff [ITERS+1];
   logic signed [Z_BITS-1:0]  z_ff [ITERS+1];
   logic [1:0]                q_ff [ITERS+1];
   logic [31:0]               phase;
   trig_type                  trig_ff, trig_in;
   logic signed [XY_BITS-1:0] c_raw, s_raw;

   assign phase = {angle, {(32-ANGLE_BITS){1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_K;
         y_ff[0] <= '0;
         z_ff[0] <= $signed({3'b000, phase[29:0]});
         q_ff[0] <= phase[31:30];
         for (int k = 0; k < ITERS; k++) begin
            q_ff[k+1] <= q_ff[k];
            if (!z_ff[k][Z_BITS-1]) begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - $signed({3'b000, ATAN_TURNS[k]});
            end else begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + $signed({3'b000, ATAN_TURNS[k]});
            end
         end
      end
   end

   // quadrant unfold, then clamp to +/- 1.0
   always_comb begin
      case (q_ff[ITERS])
         2'd0: begin
            c_raw = x_ff[ITERS];
            s_raw = y_ff[ITERS];
         end
         2'd1: begin
            c_raw = -y_ff[ITERS];
            s_raw = x_ff[ITERS];
         end
         2'd2: begin
            c_raw = -x_ff[ITERS];
            s_raw = -y_ff[ITERS];
         end
         default: begin
            c_raw = y_ff[ITERS];
            s_raw = -x_ff[ITERS];
         end
      endcase
      if (c_raw > ONE_Q30) begin
         trig_in.c = ONE_Q30[31:0];
      end else if (c_raw < -ONE_Q30) begin
         trig_in.c = -(ONE_Q30[31:0]);
      end else begin
         trig_in.c = c_raw[31:0];
      end
      if (s_raw > ONE_Q30) begin
         trig_in.s = ONE_Q30[31:0];
      end else if (s_raw < -ONE_Q30) begin
         trig_in.s = -(ONE_Q30[31:0]);
      end else begin
         trig_in.s = s_raw[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

### src/eatrm_mix.sv
// product and sum stages that form the nine basis entries
`timescale 1ns / 1ps

module eatrm_mix (
   input  logic                 clock,
   input  logic                 en,
   input  eatrm_pkg::trig_type  ti,
   input  eatrm_pkg::trig_type  tj,
   input  eatrm_pkg::trig_type  th,
   output eatrm_pkg::entry_type e [9]
);
   import eatrm_pkg::*;

   // stage 1: raw products
   logic signed [63:0] pcc_ff, pcs_ff, psc_ff, pss_ff;
   logic signed [63:0] cjch1_ff, cjsh1_ff, cjsi1_ff, cjci1_ff;
   logic signed [31:0] sj1_ff;
   // stage 2: pair products rounded to q30
   logic signed [31:0] cc2_ff, cs2_ff, sc2_ff, ss2_ff, sj2_ff;
   logic signed [63:0] cjch2_ff, cjsh2_ff, cjsi2_ff, cjci2_ff;
   logic signed [63:0] rcc, rcs, rsc, rss;
   // stage 3: products with sin j
   logic signed [63:0] sjsc3_ff, sjcc3_ff, sjss3_ff, sjcs3_ff;
   logic signed [31:0] cc3_ff, cs3_ff, sc3_ff, ss3_ff, sj3_ff;
   logic signed [63:0] cjch3_ff, cjsh3_ff, cjsi3_ff, cjci3_ff;
   // stage 4: q60 sums
   logic signed [63:0] q_ff [9];
   // stage 5: rounded and saturated entries
   entry_type          e_ff [9];

   always_ff @(posedge clock) begin
      if (en) begin
         pcc_ff   <= ti.c * th.c;
         pcs_ff   <= ti.c * th.s;
         psc_ff   <= ti.s * th.c;
         pss_ff   <= ti.s * th.s;
         cjch1_ff <= tj.c * th.c;
         cjsh1_ff <= tj.c * th.s;
         cjsi1_ff <= tj.c * ti.s;
         cjci1_ff <= tj.c * ti.c;
         sj1_ff   <= tj.s;
      end
   end

   assign rcc = (pcc_ff + (64'sd1 <<< (IQ-1))) >>> IQ;
   assign rcs = (pcs_ff + (64'sd1 <<< (IQ-1))) >>> IQ;
   assign rsc = (psc_ff + (64'sd1 <<< (IQ-1))) >>> IQ;
   assign rss = (pss_ff + (64'sd1 <<< (IQ-1))) >>> IQ;

   always_ff @(posedge clock) begin
      if (en) begin
         cc2_ff   <= rcc[31:0];
         cs2_ff   <= rcs[31:0];
         sc2_ff   <= rsc[31:0];
         ss2_ff   <= rss[31:0];
         sj2_ff   <= sj1_ff;
         cjch2_ff <= cjch1_ff;
         cjsh2_ff <= cjsh1_ff;
         cjsi2_ff <= cjsi1_ff;
         cjci2_ff <= cjci1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sjsc3_ff <= sj2_ff * sc2_ff;
         sjcc3_ff <= sj2_ff * cc2_ff;
         sjss3_ff <= sj2_ff * ss2_ff;
         sjcs3_ff <= sj2_ff * cs2_ff;
         cc3_ff   <= cc2_ff;
         cs3_ff   <= cs2_ff;
         sc3_ff   <= sc2_ff;
         ss3_ff   <= ss2_ff;
         sj3_ff   <= sj2_ff;
         cjch3_ff <= cjch2_ff;
         cjsh3_ff <= cjsh2_ff;
         cjsi3_ff <= cjsi2_ff;
         cjci3_ff <= cjci2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff[0] <= cjch3_ff;
         q_ff[1] <= sjsc3_ff - scale_q30(cs3_ff);
         q_ff[2] <= sjcc3_ff + scale_q30(ss3_ff);
         q_ff[3] <= cjsh3_ff;
         q_ff[4] <= sjss3_ff + scale_q30(cc3_ff);
         q_ff[5] <= sjcs3_ff - scale_q30(sc3_ff);
         q_ff[6] <= -scale_q30(sj3_ff);
         q_ff[7] <= cjsi3_ff;
         q_ff[8] <= cjci3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 9; n++) begin
            e_ff[n] <= to_out(q_ff[n]);
         end
      end
   end

   assign e = e_ff;

endmodule

### src/euler_angles_to_rotation_matrix.sv
// top level: xyz euler angles to the 3x3 rotation basis, stream in and out
`timescale 1ns / 1ps
// Takes one set of three 16-bit binary angles (65536 = one turn) per item and
// returns the nine basis entries as signed Q1.14, saturated to +/-16384. One
// item enters every cycle while req_tready is high; each item passes 39
// register stages before rsp_tvalid rises: 34 stages for the 32-iteration
// pipelined cordic with its load and quadrant stages, 5 for the product,
// rounding and sum stages. The whole pipeline advances together and holds
// while the output register is full and not taken, so req_tready is low
// only while rsp_tvalid is high and rsp_tready low.

`include "assert_macros.svh"

module euler_angles_to_rotation_matrix (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // angle_i, angle_j, angle_h
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata   // e00, e10, e20, e01, e11, e21, e02, e12, e22
);
   import eatrm_pkg::*;

   logic                  en;
   logic [LAT-1:0]        vld_ff, vld_in;
   trig_type              ti, tj, th;
   entry_type             e [9];

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   assign vld_in = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   eatrm_cordic u_cordic_i (
      .clock (clock),
      .en    (en),
      .angle (req_tdata[15:0]),
      .trig  (ti)
   );

   eatrm_cordic u_cordic_j (
      .clock (clock),
      .en    (en),
      .angle (req_tdata[31:16]),
      .trig  (tj)
   );

   eatrm_cordic u_cordic_h (
      .clock (clock),
      .en    (en),
      .angle (req_tdata[47:32]),
      .trig  (th)
   );

   eatrm_mix u_mix (
      .clock (clock),
      .en    (en),
      .ti    (ti),
      .tj    (tj),
      .th    (th),
      .e     (e)
   );

   assign rsp_tdata = {e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};

   `EATRM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid)
   `EATRM_ASSERT(a_ready_rule, req_tready == (!rsp_tvalid || rsp_tready))
   `EATRM_ASSERT(a_e00_range, rsp_tvalid |-> ($signed(e[0]) <= 16384 && $signed(e[0]) >= -16384))
   `EATRM_ASSERT(a_e02_range, rsp_tvalid |-> ($signed(e[6]) <= 16384 && $signed(e[6]) >= -16384))

endmodule

### dv/rotation_checker.sv
// checker: predicts the rotation basis for each accepted item and compares results
`timescale 1ns / 1ps

module rotation_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [47:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [143:0] rsp_tdata,
   output int           error_count,
   output int           pending_count
);
   import eatrm_pkg::*;

   logic [143:0] basis_queue [$];

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint clamp_unit(longint v);
      longint one;
      one = longint'(1) <<< IQ;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   // cordic sine and cosine in q30 after quadrant folding
   function automatic void angle_trig(input logic [15:0] ang, output longint s,
                                      output longint c);
      logic [31:0] phase;
      longint x, y, z, dx, dy;
      phase = {ang, 16'h0};
      x = 652032874;
      y = 0;
      z = longint'(phase[29:0]);
      for (int k = 0; k < ITERS; k++) begin
         dx = floor_shift(y, k);
         dy = floor_shift(x, k);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
         end
      end
      case (phase[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      s = clamp_unit(s);
      c = clamp_unit(c);
   endfunction

   function automatic longint mul_round(longint a, longint b);
      return (a * b + (longint'(1) <<< (IQ - 1))) >>> IQ;
   endfunction

   function automatic logic [15:0] quantize(longint q60);
      longint r, lim;
      int sh;
      sh = 2 * IQ - FRAC_BITS;
      r = (q60 + (longint'(1) <<< (sh - 1))) >>> sh;
      lim = longint'(1) <<< FRAC_BITS;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
   endfunction

   function automatic logic [143:0] predict_basis(logic [47:0] angles);
      longint si, ci, sj, cj, sh, ch, cc, cs, sc, ss, one;
      logic [143:0] m;
      angle_trig(angles[15:0], si, ci);
      angle_trig(angles[31:16], sj, cj);
      angle_trig(angles[47:32], sh, ch);
      one = longint'(1) <<< IQ;
      cc = mul_round(ci, ch);
      cs = mul_round(ci, sh);
      sc = mul_round(si, ch);
      ss = mul_round(si, sh);
      m[15:0]    = quantize(cj * ch);
      m[31:16]   = quantize(sj * sc - cs * one);
      m[47:32]   = quantize(sj * cc + ss * one);
      m[63:48]   = quantize(cj * sh);
      m[79:64]   = quantize(sj * ss + cc * one);
      m[95:80]   = quantize(sj * cs - sc * one);
      m[111:96]  = quantize(-sj * one);
      m[127:112] = quantize(cj * si);
      m[143:128] = quantize(cj * ci);
      return m;
   endfunction

   always @(posedge clock) begin
      logic [143:0] want;
      if (reset) begin
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            basis_queue.push_back(predict_basis(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (basis_queue.size() == 0) begin
               if (error_count < 10) $display("unexpected result %h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = basis_queue.pop_front();
               if (want !== rsp_tdata) begin
                  if (error_count < 10) begin
                     for (int e = 0; e < 9; e++) begin
                        if (want[e*16 +: 16] !== rsp_tdata[e*16 +: 16]) begin
                           $display("entry %0d: expected %0d got %0d", e,
                              $signed(want[e*16 +: 16]), $signed(rsp_tdata[e*16 +: 16]));
                        end
                     end
                  end
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= basis_queue.size();
      end
   end

endmodule

### dv/testbench.sv
// top of the testbench: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps

module testbench;
   import eatrm_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;  // angle_i, angle_j, angle_h
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [143:0] rsp_tdata;       // e00, e10, e20, e01, e11, e21, e02, e12, e22
   int           error_count;
   int           pending_count;
   int           cycle_count = 0;
   logic [47:0]  angle_sets [$];

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   euler_angles_to_rotation_matrix DUT (.*);

   rotation_checker checker_inst (.*);

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [15:0] random_angle();
      case ($urandom_range(0, 3))
         0: return 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 2) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver stalls: bursts of steady ready, then random stalls
   always @(posedge clock) begin
      if (reset || (cycle_count % 2000) < 300) begin
         rsp_tready <= 1;
      end else if ($urandom_range(0, 19) == 0) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      int gap;
      // quadrant edges, extremes, gimbal lock
      angle_sets.push_back({16'h0000, 16'h0000, 16'h0000});
      angle_sets.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
      angle_sets.push_back({16'h4000, 16'h4000, 16'h4000});
      angle_sets.push_back({16'h8000, 16'h8000, 16'h8000});
      angle_sets.push_back({16'hC000, 16'hC000, 16'hC000});
      angle_sets.push_back({16'h3FFF, 16'h7FFF, 16'hBFFF});
      angle_sets.push_back({16'h4001, 16'h8001, 16'hC001});
      angle_sets.push_back({16'h1234, 16'h4000, 16'h5678});
      angle_sets.push_back({16'h1234, 16'hC000, 16'h5678});
      angle_sets.push_back({16'h2000, 16'h2000, 16'h2000});
      angle_sets.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
      angle_sets.push_back({16'h5555, 16'hAAAA, 16'h5555});
      angle_sets.push_back({16'h0001, 16'hE000, 16'h6000});
      angle_sets.push_back({16'hA000, 16'h0001, 16'hFFFF});
      for (int n = 0; n < 600; n++) begin
         angle_sets.push_back({random_angle(), random_angle(), random_angle()});
      end
      repeat (6) @(posedge clock);
      reset <= 0;
      for (int n = 0; n < angle_sets.size(); n++) begin
         if (n == 300) begin
            // drain everything before carrying on
            req_tvalid <= 0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         gap = (n < 14) ? 0 : gap_length();
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1;
         req_tdata <= angle_sets[n];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
